>>> rtl/pft_pkg.sv
// Package for the trial-division prime factorizer.
// Holds the controller state type, command/status structs and fixed field widths.
// No dependencies.
package pft_pkg;

    // Fixed widths of the transaction fields
    localparam int NUMBER_W = 32;
    localparam int FACTOR_W = 32;

    // At most this many factors are emitted per number
    localparam int MAX_RESULTS    = 32;
    localparam int RESULT_COUNT_W = $clog2(MAX_RESULTS);

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_EMIT_DIV,
        ST_EMIT_LAST
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture a new number, restart the search
        logic start_div;  // launch a remainder computation
        logic inc_div;    // step to the next trial divisor
        logic emit_div;   // send the trial divisor as a non-final factor
        logic emit_last;  // send the remaining quotient as the final factor
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic sq_gt_q;    // divisor squared exceeds remaining quotient
        logic div_done;   // remainder computation finished this cycle
        logic rem_zero;   // divisor divides the quotient
        logic at_cap;     // one result slot left
        logic out_free;   // output register can take a result
    } sts_t;

endpackage

>>> rtl/pft_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
// Used by the datapath to test a trial divisor and produce the reduced quotient.
// Depends on nothing.
module pft_divider #(
    parameter int WIDTH     = 32,
    parameter int DIV_WIDTH = 17
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WIDTH-1:0]     dividend,
    input  logic [DIV_WIDTH-1:0] divisor,
    output logic                 done,
    output logic [WIDTH-1:0]     quotient,
    output logic                 rem_zero
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [WIDTH-1:0]     quo_reg, quo_next;
    logic [DIV_WIDTH-1:0] rem_reg, rem_next;

    logic [DIV_WIDTH:0]   rem_shift;
    logic [DIV_WIDTH:0]   diff;

    // One restoring step: shift in next dividend bit, subtract if it fits
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[WIDTH-1]};
        diff      = rem_shift - {1'b0, divisor};
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(WIDTH);
            quo_next = dividend;
            rem_next = '0;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (rem_shift >= {1'b0, divisor})
            begin
                rem_next = diff[DIV_WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DIV_WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign rem_zero = (rem_reg == '0);

endmodule

>>> rtl/pft_datapath.sv
// Datapath of the factorizer: quotient, trial divisor, divisor square, result
// count, output register and the iterative divider.
// Depends on pft_pkg and pft_divider.
module pft_datapath
    import pft_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic [NUMBER_W-1:0] number,
    output logic [FACTOR_W-1:0] factor,
    output logic                last,
    output logic                factor_valid,
    input  logic                factor_stall
);

    // Divisor never needs more than half the value width plus margin
    localparam int DIV_W = (VALUE_WIDTH + 1) / 2 + 1;
    localparam int SQ_W  = 2 * DIV_W;

    logic [VALUE_WIDTH-1:0]    q_reg, q_next;
    logic [DIV_W-1:0]          d_reg, d_next;
    logic [SQ_W-1:0]           sq_reg, sq_next;
    logic [RESULT_COUNT_W-1:0] n_reg, n_next;
    logic [FACTOR_W-1:0]       factor_reg, factor_next;
    logic                      last_reg, last_next;
    logic                      valid_reg, valid_next;

    logic                      div_done;
    logic                      div_rem_zero;
    logic [VALUE_WIDTH-1:0]    div_quotient;

    pft_divider #(
        .WIDTH     (VALUE_WIDTH),
        .DIV_WIDTH (DIV_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_div),
        .dividend (q_reg),
        .divisor  (d_reg),
        .done     (div_done),
        .quotient (div_quotient),
        .rem_zero (div_rem_zero)
    );

    // Search registers; square tracked incrementally: (d+1)^2 = d^2 + 2d + 1
    always_comb
    begin
        q_next  = q_reg;
        d_next  = d_reg;
        sq_next = sq_reg;
        n_next  = n_reg;
        if (cmd.load)
        begin
            q_next  = VALUE_WIDTH'(number);
            d_next  = DIV_W'(2);
            sq_next = SQ_W'(4);
            n_next  = '0;
        end
        else if (cmd.inc_div)
        begin
            d_next  = d_reg + 1'b1;
            sq_next = sq_reg + SQ_W'({d_reg, 1'b1});
        end
        else if (cmd.emit_div)
        begin
            q_next = div_quotient;
            n_next = n_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg  <= q_next;
        d_reg  <= d_next;
        sq_reg <= sq_next;
        n_reg  <= n_next;
    end

    // Output register
    always_comb
    begin
        factor_next = factor_reg;
        last_next   = last_reg;
        valid_next  = valid_reg && factor_stall;
        if (cmd.emit_div)
        begin
            factor_next = FACTOR_W'(d_reg);
            last_next   = 1'b0;
            valid_next  = 1'b1;
        end
        else if (cmd.emit_last)
        begin
            factor_next = FACTOR_W'(q_reg);
            last_next   = 1'b1;
            valid_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        factor_reg <= factor_next;
        last_reg   <= last_next;
    end

    // Status back to the controller
    always_comb
    begin
        sts.sq_gt_q  = (sq_reg > SQ_W'(q_reg));
        sts.div_done = div_done;
        sts.rem_zero = div_rem_zero;
        sts.at_cap   = (n_reg == RESULT_COUNT_W'(MAX_RESULTS - 1));
        sts.out_free = !valid_reg || !factor_stall;
    end

    assign factor       = factor_reg;
    assign last         = last_reg;
    assign factor_valid = valid_reg;

endmodule

>>> rtl/pft_controller.sv
// Controller state machine of the factorizer.
// Sequences load, divisor test, factor emission and final emission.
// Depends on pft_pkg.
module pft_controller
    import pft_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic number_valid,
    output logic number_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (number_valid)
                    state_next = ST_CHECK;
            ST_CHECK:
                if (sts.sq_gt_q)
                    state_next = ST_EMIT_LAST;
                else
                    state_next = ST_DIVIDE;
            ST_DIVIDE:
                if (sts.div_done)
                begin
                    priority if (!sts.rem_zero)
                        state_next = ST_CHECK;
                    else if (sts.at_cap)
                        state_next = ST_EMIT_LAST;
                    else
                        state_next = ST_EMIT_DIV;
                end
            ST_EMIT_DIV:
                if (sts.out_free)
                    state_next = ST_CHECK;
            ST_EMIT_LAST:
                if (sts.out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd          = '0;
        number_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                number_stall = 1'b0;
                cmd.load     = number_valid;
            end
            ST_CHECK:
                cmd.start_div = !sts.sq_gt_q;
            ST_DIVIDE:
                cmd.inc_div = sts.div_done && !sts.rem_zero;
            ST_EMIT_DIV:
                cmd.emit_div = sts.out_free;
            ST_EMIT_LAST:
                cmd.emit_last = sts.out_free;
            default:
                cmd = '0;
        endcase
    end

endmodule

>>> rtl/prime_factorizer_trial_division.sv
// Top level of the trial-division prime factorizer.
// Depends on pft_pkg, pft_controller and pft_datapath.
//
//   Input channel: number with number_valid / number_stall. One number is
//   accepted while the block is idle; number_stall stays high while a number
//   is being factored.
//   Output channel: factor and last with factor_valid / factor_stall. Prime
//   factors come smallest first, one per transaction, last set on the final
//   one. Inputs 0 and 1 give a single transaction carrying the input.
//   Sequence: each trial divisor passes through a check, the divider steps and
//   the divider's done; one that divides is also emitted. The final factor is
//   sent after the last check, so inputs 0 to 3 need a single check. A prime
//   near 2^32 runs 65534 trials. One number is in flight at a time; the final
//   factor sits in an output register, so the next number can be accepted
//   while it waits.
//   Stall: a stalled output holds its transaction; the search pauses at the
//   next factor until the output register frees up.
//   Reset: rst_n is asynchronous, active low; comes up idle, no output pending.
module prime_factorizer_trial_division
    import pft_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [NUMBER_W-1:0] number,
    input  logic                number_valid,
    output logic                number_stall,
    output logic [FACTOR_W-1:0] factor,
    output logic                last,
    output logic                factor_valid,
    input  logic                factor_stall
);

    cmd_t cmd;
    sts_t sts;

    pft_controller u_controller (
        .clk          (clk),
        .rst_n        (rst_n),
        .number_valid (number_valid),
        .number_stall (number_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    pft_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .number       (number),
        .factor       (factor),
        .last         (last),
        .factor_valid (factor_valid),
        .factor_stall (factor_stall)
    );

endmodule

>>> sim/prime_factorizer_trial_division_checker.sv
`timescale 1ns / 100ps
// Checker for the trial-division prime factorizer: watches both channels,
// predicts the factor stream of every accepted number and compares results.
// Depends on pft_pkg.
module prime_factorizer_trial_division_checker
    import pft_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [NUMBER_W-1:0] number,
    input  logic                number_valid,
    input  logic                number_stall,
    input  logic [FACTOR_W-1:0] factor,
    input  logic                last,
    input  logic                factor_valid,
    input  logic                factor_stall,
    output int                  mismatch_count,
    output int                  outstanding
);

    localparam logic [63:0] WIDTH_MASK =
        (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);

    typedef struct packed {
        logic [FACTOR_W-1:0] factor;
        logic                last;
    } factor_rec_t;

    factor_rec_t expected_factors[$];
    factor_rec_t oldest;

    initial begin
        mismatch_count = 0;
        outstanding    = 0;
    end

    // One line per mismatch, then count it
    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $realtime, msg);
        mismatch_count = mismatch_count + 1;
    endtask

    function automatic factor_rec_t make_rec(input logic [63:0] value, input logic fin);
        factor_rec_t rec;
        rec.factor = value[FACTOR_W-1:0];
        rec.last   = fin;
        return rec;
    endfunction

    // Trial division: smallest divisor first, repeated factors kept,
    // leftover quotient above one is the final factor
    task automatic predict_factors(input logic [NUMBER_W-1:0] value);
        logic [63:0] quotient;
        logic [63:0] divisor;
        int          count;
        factor_rec_t rec;
        quotient = {{(64-NUMBER_W){1'b0}}, value} & WIDTH_MASK;
        divisor  = 64'd2;
        count    = 0;
        if (quotient < 64'd2) begin
            expected_factors.push_back(make_rec(quotient, 1'b1));
        end
        else begin
            while (divisor <= quotient / divisor) begin
                if (quotient % divisor == 64'd0) begin
                    // result cap: remainder goes out as the final result
                    if (count == MAX_RESULTS - 1)
                        break;
                    expected_factors.push_back(make_rec(divisor, 1'b0));
                    count    = count + 1;
                    quotient = quotient / divisor;
                end
                else begin
                    divisor = divisor + 64'd1;
                end
            end
            if (quotient > 64'd1) begin
                expected_factors.push_back(make_rec(quotient, 1'b1));
            end
            else begin
                // quotient fully divided out: last divisor closes the number
                rec = expected_factors.pop_back();
                rec.last = 1'b1;
                expected_factors.push_back(rec);
            end
        end
    endtask

    // Compare the output transaction first, then predict from the input one
    always @(posedge clk) begin
        if (rst_n) begin
            if (factor_valid === 1'b1 && factor_stall === 1'b0) begin
                if (expected_factors.size() == 0) begin
                    report_mismatch($sformatf("unexpected factor %0d last %0b",
                                              factor, last));
                end
                else begin
                    oldest = expected_factors.pop_front();
                    if (factor !== oldest.factor)
                        report_mismatch($sformatf("factor got %0d expected %0d",
                                                  factor, oldest.factor));
                    if (last !== oldest.last)
                        report_mismatch($sformatf("last got %0b expected %0b on factor %0d",
                                                  last, oldest.last, oldest.factor));
                end
            end
            if (number_valid === 1'b1 && number_stall === 1'b0)
                predict_factors(number);
        end
        outstanding <= expected_factors.size();
    end

endmodule

>>> sim/prime_factorizer_trial_division_test.sv
`timescale 1ns / 100ps
// Testbench top for the trial-division prime factorizer: clock, reset,
// number stimulus and output stall; verdict from the checker's count.
// Depends on pft_pkg, prime_factorizer_trial_division and its checker.
module prime_factorizer_trial_division_test;
    import pft_pkg::*;

    localparam int CYCLE_LIMIT  = 6_000_000;
    localparam int RANDOM_ITEMS = 100;
    localparam int DRAIN_CYCLES = 200;

    logic                clk;
    logic                rst_n;
    logic [NUMBER_W-1:0] number;
    logic                number_valid;
    logic                number_stall;
    logic [FACTOR_W-1:0] factor;
    logic                last;
    logic                factor_valid;
    logic                factor_stall;

    int mismatch_count;
    int outstanding;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;

    // Small primes for building numbers whose search stays short
    int unsigned small_primes[25] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37,
                                      41, 43, 47, 53, 59, 61, 67, 71, 73, 79,
                                      83, 89, 97};

    // Edge values, primes, squares, powers and highly composite numbers
    logic [31:0] directed_numbers[20] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4,
        32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_0000,
        32'd65521, 32'd65537, 32'd9409, 32'd25, 32'd6,
        32'd223092870, 32'h5555_5555, 32'hAAAA_AAAA, 32'd3486784401,
        32'd4293984256, 32'd97
    };

    prime_factorizer_trial_division u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .number       (number),
        .number_valid (number_valid),
        .number_stall (number_stall),
        .factor       (factor),
        .last         (last),
        .factor_valid (factor_valid),
        .factor_stall (factor_stall)
    );

    prime_factorizer_trial_division_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .number         (number),
        .number_valid   (number_valid),
        .number_stall   (number_stall),
        .factor         (factor),
        .last           (last),
        .factor_valid   (factor_valid),
        .factor_stall   (factor_stall),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        number        = '0;
        number_valid  = 1'b0;
        factor_stall  = 1'b0;
        cycle_count   = 0;
        send_idle_pct = 18;
        recv_idle_pct = 48;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge clk) begin
        factor_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("prime_factorizer_trial_division_test NOT OK");
            $finish;
        end
    end

    // Offer one number and return at the edge where it is accepted.
    // Valid stays high between back-to-back transactions.
    task automatic send_number(input logic [NUMBER_W-1:0] value);
        if ($urandom_range(99) < send_idle_pct) begin
            number_valid <= 1'b0;
            number       <= $urandom;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        number       <= value;
        number_valid <= 1'b1;
        @(posedge clk);
        while (number_stall !== 1'b0)
            @(posedge clk);
    endtask

    // Mostly smooth numbers with random content, some noise and tiny values
    function automatic logic [NUMBER_W-1:0] random_number();
        longint unsigned value;
        longint unsigned p;
        int              picks;
        int              sel;
        sel = $urandom_range(99);
        if (sel < 6)
            return $urandom_range(3);
        if (sel < 16)
            return $urandom & 32'h0000_FFFF;
        value = 1;
        picks = $urandom_range(1, 30);
        repeat (picks) begin
            p = small_primes[$urandom_range($urandom_range(24))];
            if (value * p <= 64'hFFFF_FFFF)
                value = value * p;
        end
        if ($urandom_range(1)) begin
            p = $urandom_range(2, 16383);
            if (value * p <= 64'hFFFF_FFFF)
                value = value * p;
        end
        return value[NUMBER_W-1:0];
    endfunction

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed numbers
        foreach (directed_numbers[i])
            send_number(directed_numbers[i]);

        // Random numbers over three idling patterns
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 18; recv_idle_pct = 48; end
                1: begin send_idle_pct = 48; recv_idle_pct = 18; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 3 + (phase == 0); n++)
                send_number(random_number());
        end
        number_valid <= 1'b0;

        // Drain all expected factors, then watch for stray output
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("prime_factorizer_trial_division_test OK");
        else
            $display("prime_factorizer_trial_division_test NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
rtl/pft_pkg.sv
rtl/pft_divider.sv
rtl/pft_datapath.sv
rtl/pft_controller.sv
rtl/prime_factorizer_trial_division.sv
sim/prime_factorizer_trial_division_checker.sv
sim/prime_factorizer_trial_division_test.sv
